>>> rtl/bpa_pkg.sv
// Package for the buddy page allocator: sizing constants, codes, state
// encodings and the frame-table entry format. No dependencies.
package bpa_pkg;

   localparam int FRAME_COUNT      = 1024;
   localparam int TOP_ORDER        = 10;
   localparam int FRAME_BYTES_LOG2 = 12;

   localparam int IDX_W   = $clog2(FRAME_COUNT);
   localparam int ORD_W   = 5;
   localparam int ENTRY_W = 2 + ORD_W;

   typedef enum logic [1:0] {
      STAT_FREE   = 2'd0,
      STAT_USED   = 2'd1,
      STAT_INSIDE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OUT_OK        = 2'd0,
      OUT_NO_MEMORY = 2'd1,
      OUT_ALREADY   = 2'd2,
      OUT_BAD_ADDR  = 2'd3
   } outcome_type;

   typedef enum logic [0:0] {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SPLIT,
      ST_FCHECK,
      ST_MREAD,
      ST_MCHK,
      ST_MFIN
   } state_type;

   typedef struct packed {
      logic [ORD_W-1:0] alloc_order;
      logic             too_big;
      logic             addr_bad;
      logic [IDX_W-1:0] frame_idx;
   } decode_type;

   function automatic logic [ENTRY_W-1:0] make_entry(input logic [1:0] st,
                                                     input logic [ORD_W-1:0] ord);
      make_entry = {st, ord};
   endfunction

endpackage

>>> rtl/bpa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> rtl/bpa_decode.sv
// Request decoder: turns a byte count into a block order and checks a free address.
// Depends on bpa_pkg.
module bpa_decode (
   input  logic [31:0]         request_bytes,
   input  logic [31:0]         block_address,
   input  logic [31:0]         pool_base,
   output bpa_pkg::decode_type dec
);

   logic [31:0] offset;

   assign offset = block_address - pool_base;

   // The smallest order whose block holds the request; past the top order means too big.
   always_comb begin
      dec.alloc_order = bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER + 1);
      for (int j = bpa_pkg::TOP_ORDER; j >= 0; j--) begin
         if ({32'd0, request_bytes} <= (64'd1 << (bpa_pkg::FRAME_BYTES_LOG2 + j))) begin
            dec.alloc_order = bpa_pkg::ORD_W'(j);
         end
      end
      dec.too_big = (dec.alloc_order > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
      dec.addr_bad = (block_address < pool_base)
                   || (offset[bpa_pkg::FRAME_BYTES_LOG2-1:0] != '0)
                   || ((offset >> bpa_pkg::FRAME_BYTES_LOG2) >= 32'(bpa_pkg::FRAME_COUNT));
      dec.frame_idx = bpa_pkg::IDX_W'(offset >> bpa_pkg::FRAME_BYTES_LOG2);
   end

endmodule

>>> rtl/buddy_page_allocator_unit.sv
// Buddy page allocator: one request at a time over a frame table held in a RAM.
// Allocate scans the table with one read per cycle and stops early on an exact fit, then
// splits the chosen block down; free checks the frame and then merges with free buddies.
// The next transfer may land in the result cycle, and the receiver cannot stall.
// After reset a clearing pass rebuilds the table with busy high; csr writes are taken
// during it. Depends on bpa_pkg, bpa_ram, bpa_decode.
module buddy_page_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_block_address,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_outcome,
   output logic [31:0] rsp_granted_address,
   output logic [3:0]  rsp_block_order,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_pool_base
);

   localparam logic [bpa_pkg::IDX_W-1:0] LAST_IDX = bpa_pkg::IDX_W'(bpa_pkg::FRAME_COUNT - 1);

   bpa_pkg::state_type state_ff, state_in;

   // Clearing pass counter.
   logic [bpa_pkg::IDX_W-1:0] clr_ff, clr_in;

   // Latched request and configuration.
   logic        kind_ff, kind_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] base_ff;
   logic [bpa_pkg::ORD_W-1:0] k_ff, k_in;

   // Scan state: issue pointer, one read in flight, best candidate so far.
   logic [bpa_pkg::IDX_W-1:0] scan_ff, scan_in;
   logic                      scan_done_ff, scan_done_in;
   logic                      rd_v_ff, rd_v_in;
   logic [bpa_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic                      best_v_ff, best_v_in;
   logic [bpa_pkg::IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [bpa_pkg::ORD_W-1:0] best_ord_ff, best_ord_in;
   logic [bpa_pkg::ORD_W-1:0] s_ff, s_in;

   // Merge state: current block head and its order.
   logic [bpa_pkg::IDX_W-1:0] cur_ff, cur_in;
   logic [bpa_pkg::ORD_W-1:0] ord_ff, ord_in;

   // Result registers.
   logic        strobe_ff, strobe_in;
   logic [1:0]  outcome_ff, outcome_in;
   logic [31:0] gaddr_ff, gaddr_in;
   logic [3:0]  gord_ff, gord_in;

   // RAM port.
   logic                          ram_we, ram_re;
   logic [bpa_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [bpa_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
   logic [1:0]                    rd_stat;
   logic [bpa_pkg::ORD_W-1:0]     rd_ord;

   bpa_pkg::decode_type dec;

   // Scan helpers.
   logic                      hit;
   logic                      nb_v;
   logic [bpa_pkg::IDX_W-1:0] nb_idx;
   logic [bpa_pkg::ORD_W-1:0] nb_ord;
   logic [bpa_pkg::ORD_W-1:0] s_dec;
   logic [bpa_pkg::IDX_W:0]   half;
   logic [bpa_pkg::IDX_W:0]   buddy;
   logic [bpa_pkg::IDX_W-1:0] buddy_idx;

   bpa_ram #(
      .WIDTH (bpa_pkg::ENTRY_W),
      .DEPTH (bpa_pkg::FRAME_COUNT)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bpa_decode u_decode (
      .request_bytes (bytes_ff),
      .block_address (addr_ff),
      .pool_base     (base_ff),
      .dec           (dec)
   );

   assign rd_stat   = ram_rdata[bpa_pkg::ENTRY_W-1 -: 2];
   assign rd_ord    = ram_rdata[bpa_pkg::ORD_W-1:0];
   assign busy      = (state_ff != bpa_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_strobe          = strobe_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_granted_address = gaddr_ff;
   assign rsp_block_order     = gord_ff;

   // A free block of a usable order that beats the best one seen so far. The scan
   // runs in index order, so the first hit of each order is the lowest index.
   always_comb begin
      hit = rd_v_ff && (rd_stat == bpa_pkg::STAT_FREE) && (rd_ord >= k_ff)
            && (!best_v_ff || (rd_ord < best_ord_ff));
      nb_v   = best_v_ff || hit;
      nb_idx = hit ? rd_idx_ff : best_idx_ff;
      nb_ord = hit ? rd_ord : best_ord_ff;
      s_dec  = s_ff - bpa_pkg::ORD_W'(1);
      half   = {1'b0, best_idx_ff} + ((bpa_pkg::IDX_W+1)'(1) << s_dec);
      buddy  = {1'b0, cur_ff} ^ ((bpa_pkg::IDX_W+1)'(1) << ord_ff);
      buddy_idx = buddy[bpa_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bpa_pkg::ST_CLEAR;
         clr_ff    <= '0;
         base_ff   <= '0;
         rd_v_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rd_v_ff   <= rd_v_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            base_ff <= csr_pool_base;
         end
      end
      kind_ff      <= kind_in;
      bytes_ff     <= bytes_in;
      addr_ff      <= addr_in;
      k_ff         <= k_in;
      scan_ff      <= scan_in;
      scan_done_ff <= scan_done_in;
      rd_idx_ff    <= rd_idx_in;
      best_v_ff    <= best_v_in;
      best_idx_ff  <= best_idx_in;
      best_ord_ff  <= best_ord_in;
      s_ff         <= s_in;
      cur_ff       <= cur_in;
      ord_ff       <= ord_in;
      outcome_ff   <= outcome_in;
      gaddr_ff     <= gaddr_in;
      gord_ff      <= gord_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      bytes_in     = bytes_ff;
      addr_in      = addr_ff;
      k_in         = k_ff;
      scan_in      = scan_ff;
      scan_done_in = scan_done_ff;
      rd_v_in      = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_v_in    = best_v_ff;
      best_idx_in  = best_idx_ff;
      best_ord_in  = best_ord_ff;
      s_in         = s_ff;
      cur_in       = cur_ff;
      ord_in       = ord_ff;
      strobe_in    = 1'b0;
      outcome_in   = outcome_ff;
      gaddr_in     = gaddr_ff;
      gord_in      = gord_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      unique case (state_ff)
         // Frame 0 becomes one free block of the top order; all other frames
         // lie inside it.
         bpa_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = (clr_ff == '0)
                      ? bpa_pkg::make_entry(bpa_pkg::STAT_FREE,
                                            bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER))
                      : bpa_pkg::make_entry(bpa_pkg::STAT_INSIDE, '0);
            clr_in = clr_ff + bpa_pkg::IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end

         bpa_pkg::ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               bytes_in = req_request_bytes;
               addr_in  = req_block_address;
               state_in = bpa_pkg::ST_DECODE;
            end
         end

         bpa_pkg::ST_DECODE: begin
            gaddr_in = '0;
            gord_in  = '0;
            if (kind_ff == bpa_pkg::KIND_ALLOC) begin
               k_in = dec.alloc_order;
               if (dec.too_big) begin
                  strobe_in  = 1'b1;
                  outcome_in = bpa_pkg::OUT_NO_MEMORY;
                  state_in   = bpa_pkg::ST_IDLE;
               end else begin
                  scan_in      = '0;
                  scan_done_in = 1'b0;
                  best_v_in    = 1'b0;
                  state_in     = bpa_pkg::ST_SCAN;
               end
            end else begin
               if (dec.addr_bad) begin
                  strobe_in  = 1'b1;
                  outcome_in = bpa_pkg::OUT_BAD_ADDR;
                  state_in   = bpa_pkg::ST_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = dec.frame_idx;
                  cur_in    = dec.frame_idx;
                  state_in  = bpa_pkg::ST_FCHECK;
               end
            end
         end

         // One read issued per cycle; the entry read in the previous cycle is judged.
         bpa_pkg::ST_SCAN: begin
            if (!scan_done_ff) begin
               ram_re       = 1'b1;
               ram_raddr    = scan_ff;
               rd_v_in      = 1'b1;
               rd_idx_in    = scan_ff;
               scan_in      = scan_ff + bpa_pkg::IDX_W'(1);
               scan_done_in = (scan_ff == LAST_IDX);
            end
            best_v_in   = nb_v;
            best_idx_in = nb_idx;
            best_ord_in = nb_ord;
            if ((hit && (rd_ord == k_ff)) || (rd_v_ff && (rd_idx_ff == LAST_IDX))) begin
               rd_v_in = 1'b0;
               if (nb_v) begin
                  s_in     = nb_ord;
                  state_in = bpa_pkg::ST_SPLIT;
               end else begin
                  strobe_in  = 1'b1;
                  outcome_in = bpa_pkg::OUT_NO_MEMORY;
                  state_in   = bpa_pkg::ST_IDLE;
               end
            end
         end

         // Each step frees the upper half of the block at one order lower.
         bpa_pkg::ST_SPLIT: begin
            if (s_ff > k_ff) begin
               s_in = s_dec;
               if (half < (bpa_pkg::IDX_W+1)'(bpa_pkg::FRAME_COUNT)) begin
                  ram_we    = 1'b1;
                  ram_waddr = half[bpa_pkg::IDX_W-1:0];
                  ram_wdata = bpa_pkg::make_entry(bpa_pkg::STAT_FREE, s_dec);
               end
            end else begin
               ram_we     = 1'b1;
               ram_waddr  = best_idx_ff;
               ram_wdata  = bpa_pkg::make_entry(bpa_pkg::STAT_USED, k_ff);
               strobe_in  = 1'b1;
               outcome_in = bpa_pkg::OUT_OK;
               gaddr_in   = base_ff
                          + (32'(best_idx_ff) << bpa_pkg::FRAME_BYTES_LOG2);
               gord_in    = k_ff[3:0];
               state_in   = bpa_pkg::ST_IDLE;
            end
         end

         bpa_pkg::ST_FCHECK: begin
            ord_in = rd_ord;
            if (rd_stat == bpa_pkg::STAT_FREE) begin
               strobe_in  = 1'b1;
               outcome_in = bpa_pkg::OUT_ALREADY;
               state_in   = bpa_pkg::ST_IDLE;
            end else if (rd_stat != bpa_pkg::STAT_USED) begin
               strobe_in  = 1'b1;
               outcome_in = bpa_pkg::OUT_BAD_ADDR;
               state_in   = bpa_pkg::ST_IDLE;
            end else begin
               state_in = bpa_pkg::ST_MREAD;
            end
         end

         // The head itself is written free once, when merging ends; the buddy
         // reads never touch frames inside the block being built.
         bpa_pkg::ST_MREAD: begin
            if ((ord_ff >= bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER))
                || (buddy >= (bpa_pkg::IDX_W+1)'(bpa_pkg::FRAME_COUNT))) begin
               state_in = bpa_pkg::ST_MFIN;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = buddy_idx;
               state_in  = bpa_pkg::ST_MCHK;
            end
         end

         bpa_pkg::ST_MCHK: begin
            if ((rd_stat == bpa_pkg::STAT_FREE) && (rd_ord == ord_ff)) begin
               ram_we    = 1'b1;
               ram_waddr = (buddy_idx < cur_ff) ? cur_ff : buddy_idx;
               ram_wdata = bpa_pkg::make_entry(bpa_pkg::STAT_INSIDE, '0);
               cur_in    = (buddy_idx < cur_ff) ? buddy_idx : cur_ff;
               ord_in    = ord_ff + bpa_pkg::ORD_W'(1);
               state_in  = bpa_pkg::ST_MREAD;
            end else begin
               state_in = bpa_pkg::ST_MFIN;
            end
         end

         bpa_pkg::ST_MFIN: begin
            ram_we     = 1'b1;
            ram_waddr  = cur_ff;
            ram_wdata  = bpa_pkg::make_entry(bpa_pkg::STAT_FREE, ord_ff);
            strobe_in  = 1'b1;
            outcome_in = bpa_pkg::OUT_OK;
            gord_in    = ord_ff[3:0];
            state_in   = bpa_pkg::ST_IDLE;
         end

         default: begin
            state_in = bpa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> test/bpa_checker.sv
`timescale 1ns / 1ps
// Checker for the buddy page allocator: watches the request, response and csr
// channels, keeps its own copy of the frame table and compares every response.
// Depends on bpa_pkg.
module bpa_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_block_address,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_outcome,
   input  logic [31:0] rsp_granted_address,
   input  logic [3:0]  rsp_block_order,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_pool_base,
   input  logic        run_done,
   output int          failures
);

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] address;
      logic [3:0]  order;
   } grant_type;

   bpa_pkg::status_type frame_stat [bpa_pkg::FRAME_COUNT];
   logic [3:0]          frame_ord  [bpa_pkg::FRAME_COUNT];
   logic [31:0]         base_reg;
   grant_type           awaited_grants [$];
   bit                  closed;

   function automatic grant_type allocate_frames(input logic [31:0] bytes);
      grant_type r;
      int        k;
      int        s;
      int        hit;
      logic [31:0] half;
      r = '0;
      k = 0;
      hit = -1;
      while (k <= bpa_pkg::TOP_ORDER
             && ((64'd1 << (bpa_pkg::FRAME_BYTES_LOG2 + k)) < {32'd0, bytes}))
         k++;
      if (k > bpa_pkg::TOP_ORDER) begin
         r.outcome = bpa_pkg::OUT_NO_MEMORY;
         return r;
      end
      for (int o = k; o <= bpa_pkg::TOP_ORDER && hit < 0; o++) begin
         for (int i = 0; i < bpa_pkg::FRAME_COUNT && hit < 0; i++) begin
            if (frame_stat[i] == bpa_pkg::STAT_FREE && frame_ord[i] == o) begin
               hit = i;
               s = o;
               while (s > k) begin
                  s--;
                  half = i + (32'd1 << s);
                  if (half < bpa_pkg::FRAME_COUNT) begin
                     frame_stat[half] = bpa_pkg::STAT_FREE;
                     frame_ord[half] = s[3:0];
                  end
               end
               frame_stat[i] = bpa_pkg::STAT_USED;
               frame_ord[i] = k[3:0];
            end
         end
      end
      if (hit < 0) begin
         r.outcome = bpa_pkg::OUT_NO_MEMORY;
         return r;
      end
      r.outcome = bpa_pkg::OUT_OK;
      r.address = base_reg + (32'(hit) << bpa_pkg::FRAME_BYTES_LOG2);
      r.order = k[3:0];
      return r;
   endfunction

   function automatic grant_type release_block(input logic [31:0] addr);
      grant_type   r;
      logic [31:0] offset;
      logic [31:0] idx;
      logic [31:0] cur;
      logic [31:0] buddy;
      logic [31:0] lo;
      logic [31:0] hi;
      int          ord;
      r = '0;
      offset = addr - base_reg;
      idx = offset >> bpa_pkg::FRAME_BYTES_LOG2;
      if (addr < base_reg || offset[bpa_pkg::FRAME_BYTES_LOG2-1:0] != 0
          || idx >= bpa_pkg::FRAME_COUNT) begin
         r.outcome = bpa_pkg::OUT_BAD_ADDR;
         return r;
      end
      if (frame_stat[idx] == bpa_pkg::STAT_FREE) begin
         r.outcome = bpa_pkg::OUT_ALREADY;
         return r;
      end
      if (frame_stat[idx] != bpa_pkg::STAT_USED) begin
         r.outcome = bpa_pkg::OUT_BAD_ADDR;
         return r;
      end
      cur = idx;
      ord = frame_ord[idx];
      frame_stat[cur] = bpa_pkg::STAT_FREE;
      // Coalesce upward while the buddy is a free head of the same size.
      while (ord < bpa_pkg::TOP_ORDER) begin
         buddy = cur ^ (32'd1 << ord);
         if (buddy >= bpa_pkg::FRAME_COUNT) break;
         if (frame_stat[buddy] != bpa_pkg::STAT_FREE || frame_ord[buddy] != ord) break;
         lo = (buddy < cur) ? buddy : cur;
         hi = (buddy < cur) ? cur : buddy;
         frame_stat[hi] = bpa_pkg::STAT_INSIDE;
         frame_ord[hi] = '0;
         cur = lo;
         ord++;
         frame_stat[cur] = bpa_pkg::STAT_FREE;
         frame_ord[cur] = ord[3:0];
      end
      r.outcome = bpa_pkg::OUT_OK;
      r.order = ord[3:0];
      return r;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         for (int i = 0; i < bpa_pkg::FRAME_COUNT; i++) begin
            frame_stat[i] = bpa_pkg::STAT_INSIDE;
            frame_ord[i] = '0;
         end
         frame_stat[0] = bpa_pkg::STAT_FREE;
         frame_ord[0] = 4'(bpa_pkg::TOP_ORDER);
         base_reg = '0;
         awaited_grants.delete();
         failures = 0;
         closed = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_grants.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = awaited_grants.pop_front();
               if (rsp_outcome !== want.outcome) begin
                  $error("outcome expected %0d got %0d", want.outcome, rsp_outcome);
                  failures++;
               end
               if (rsp_granted_address !== want.address) begin
                  $error("granted_address expected %h got %h", want.address,
                         rsp_granted_address);
                  failures++;
               end
               if (rsp_block_order !== want.order) begin
                  $error("block_order expected %0d got %0d", want.order, rsp_block_order);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            if (req_kind == bpa_pkg::KIND_ALLOC)
               awaited_grants.push_back(allocate_frames(req_request_bytes));
            else
               awaited_grants.push_back(release_block(req_block_address));
         end
         if (csr_valid && csr_ready)
            base_reg = csr_pool_base;
         if (run_done && !closed) begin
            closed = 1;
            if (awaited_grants.size() != 0) begin
               $error("%0d responses never arrived", awaited_grants.size());
               failures += awaited_grants.size();
            end
         end
      end
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top of the buddy page allocator testbench: clock, reset, stimulus and verdict.
// Depends on bpa_pkg, buddy_page_allocator_unit and bpa_checker.
module testbench;

   // The watchdog allows for the post-reset clearing pass plus a full-table scan
   // and the longest sender gap, several times over.
   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_kind;
   logic [31:0] req_request_bytes;
   logic [31:0] req_block_address;
   logic        rsp_strobe;
   logic [1:0]  rsp_outcome;
   logic [31:0] rsp_granted_address;
   logic [3:0]  rsp_block_order;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_pool_base;
   logic        run_done;
   int          failures;

   // Mirror of the pool base for building free addresses, the kinds of requests
   // still in flight, and the frame indexes of blocks we currently own.
   logic [31:0]       pool_base_now;
   bpa_pkg::kind_type kinds_in_flight [$];
   int                owned_frames [$];
   int                idle_cycles;
   int                n_granted, n_no_memory, n_freed, n_rejected, n_bases;

   buddy_page_allocator_unit uut (.*);

   bpa_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Every response is tracked here so that later frees can target live blocks.
   always @(posedge clock) begin
      bpa_pkg::kind_type k;
      if (!reset && rsp_strobe && kinds_in_flight.size() != 0) begin
         k = kinds_in_flight.pop_front();
         if (k == bpa_pkg::KIND_ALLOC) begin
            if (rsp_outcome == bpa_pkg::OUT_OK) begin
               n_granted++;
               owned_frames.push_back(int'((rsp_granted_address - pool_base_now)
                                           >> bpa_pkg::FRAME_BYTES_LOG2));
            end else begin
               n_no_memory++;
            end
         end else if (rsp_outcome == bpa_pkg::OUT_OK) begin
            n_freed++;
         end else begin
            n_rejected++;
         end
      end
   end

   // Watchdog: any transfer on any channel resets the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // One request transfer with a random lead-in gap; start stays high when the
   // gap is zero so back-to-back requests are also exercised.
   task automatic send(input bpa_pkg::kind_type kind, input logic [31:0] bytes,
                       input logic [31:0] addr);
      int gap;
      gap = $urandom_range(7);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_request_bytes <= bytes;
      req_block_address <= addr;
      do @(posedge clock); while (busy);
      kinds_in_flight.push_back(kind);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (kinds_in_flight.size() != 0) @(posedge clock);
   endtask

   // Pool base is only changed with no request outstanding.
   task automatic set_base(input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_pool_base <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_base_now = value;
      n_bases++;
   endtask

   function automatic logic [31:0] frame_addr(input int idx);
      return pool_base_now + (32'(idx) << bpa_pkg::FRAME_BYTES_LOG2);
   endfunction

   task automatic random_request();
      int pick;
      int slot;
      pick = $urandom_range(99);
      if (pick < 40 && owned_frames.size() != 0) begin
         // Well-formed free of a block we hold.
         slot = $urandom_range(owned_frames.size() - 1);
         send(bpa_pkg::KIND_FREE, $urandom(), frame_addr(owned_frames[slot]));
         owned_frames.delete(slot);
      end else if (pick < 52) begin
         // Malformed or stale frees: random, misaligned, below base, or any frame.
         case ($urandom_range(3))
            0: send(bpa_pkg::KIND_FREE, $urandom(), $urandom());
            1: send(bpa_pkg::KIND_FREE, $urandom(),
                    frame_addr($urandom_range(bpa_pkg::FRAME_COUNT - 1))
                    + $urandom_range(1, 4095));
            2: send(bpa_pkg::KIND_FREE, $urandom(), pool_base_now - $urandom_range(1, 8192));
            default: send(bpa_pkg::KIND_FREE, $urandom(),
                          frame_addr($urandom_range(bpa_pkg::FRAME_COUNT)));
         endcase
      end else begin
         case ($urandom_range(9))
            0: send(bpa_pkg::KIND_ALLOC, $urandom(), $urandom());
            1: send(bpa_pkg::KIND_ALLOC, $urandom_range(32'h0050_0000), $urandom());
            default: send(bpa_pkg::KIND_ALLOC, $urandom_range(32'h0000_8000), $urandom());
         endcase
      end
   endtask

   initial begin
      logic [31:0] phase_bases [5];
      phase_bases = '{32'hFFFF_F000, 32'h0000_0000, $urandom() & 32'hFFFF_F000,
                      $urandom(), 32'hFFFF_FFFF};
      reset = 1'b1;
      start = 1'b0;
      req_kind = bpa_pkg::KIND_ALLOC;
      req_request_bytes = '0;
      req_block_address = '0;
      csr_valid = 1'b0;
      csr_pool_base = '0;
      run_done = 1'b0;
      pool_base_now = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the pool at address zero.
      set_base(32'h0000_0000);
      send(bpa_pkg::KIND_ALLOC, 32'd0, 32'hFFFF_FFFF);          // zero-byte request
      send(bpa_pkg::KIND_ALLOC, 32'd1, 32'd0);
      send(bpa_pkg::KIND_ALLOC, 32'd4097, 32'd0);               // rounds up to two frames
      send(bpa_pkg::KIND_ALLOC, 32'd16384, 32'd0);
      send(bpa_pkg::KIND_ALLOC, 32'h0040_0000, 32'd0);          // whole pool, none left
      send(bpa_pkg::KIND_ALLOC, 32'h0040_0001, 32'd0);          // above the top order
      send(bpa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send(bpa_pkg::KIND_FREE, 32'hFFFF_FFFF, 32'h0000_3000);   // inside a block
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_1001);           // misaligned
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0040_0000);           // past the last frame
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_8000);           // a free head
      send(bpa_pkg::KIND_FREE, 32'd0, 32'hFFFF_FFFF);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_0000);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_1000);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_2000);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_4000);           // merges back to the top
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_0000);           // already free
      send(bpa_pkg::KIND_ALLOC, 32'h0040_0000, 32'd0);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_0000);
      drain();
      owned_frames.delete();

      // Highest base: the grant lands at the base itself and low addresses fall below it.
      set_base(32'hFFFF_FFFF);
      send(bpa_pkg::KIND_ALLOC, 32'd1, 32'd0);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'h0000_0FFF);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'hFFFF_FFFE);
      send(bpa_pkg::KIND_FREE, 32'd0, 32'hFFFF_FFFF);
      drain();
      owned_frames.delete();

      // Random phases, each under its own pool base.
      foreach (phase_bases[p]) begin
         set_base(phase_bases[p]);
         repeat (205) random_request();
      end
      drain();

      repeat (40) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Covered %0d allocations granted, %0d out of memory, %0d frees, %0d",
               n_granted, n_no_memory, n_freed, n_rejected);
      $display("rejected frees, across %0d pool base settings.", n_bases);
      if (failures == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
